/* hw/rtl/spn16_ctr_keystream_cipher_core_defines.svh */
// Assertion macros shared by the cipher core RTL.
// Each use expects signals named clk and rst_n in the enclosing module.
`ifndef SPN16_CTR_KEYSTREAM_CIPHER_CORE_DEFINES_SVH
`define SPN16_CTR_KEYSTREAM_CIPHER_CORE_DEFINES_SVH

`ifndef SYNTHESIS
// Same-cycle implication
`define SPN16_ASSERT_IMPL(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);
// Next-cycle implication
`define SPN16_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);
`else
`define SPN16_ASSERT_IMPL(lbl, ante, cons, msg)
`define SPN16_ASSERT_NEXT(lbl, ante, cons, msg)
`endif

`endif

/* hw/rtl/spn16_pkg.sv */
package spn16_pkg;

  // Cipher constants
  localparam int unsigned ROUNDS      = 3;
  localparam logic [7:0]  KEY_RCON1   = 8'h80;
  localparam logic [7:0]  KEY_RCON2   = 8'h30;
  localparam logic [7:0]  NIB_MASK    = 8'h0F;
  localparam logic [23:0] PBOX_RESET  = 24'hFAC688;

  // Register indexes on the configuration port
  localparam logic [1:0] REG_CIPHER_KEY   = 2'd0;
  localparam logic [1:0] REG_PBOX_CODES   = 2'd1;
  localparam logic [1:0] REG_COUNTER_HIGH = 2'd2;

  typedef struct packed {
    logic [15:0] cipher_key;
    logic [23:0] pbox_codes;
    logic [7:0]  counter_high;
  } cfg_t;

  typedef struct packed {
    logic       wr_en;
    logic [7:0] wr_addr;
    logic [7:0] wr_data;
    logic       rd_en;
    logic [7:0] rd_addr0;
    logic [7:0] rd_addr1;
  } ram_req_t;

  // Exchange the two nibbles of a byte
  function automatic logic [7:0] nib_swap(input logic [7:0] b);
    return ((b & NIB_MASK) << 4) | ((b >> 4) & NIB_MASK);
  endfunction

  // Output bit 7-i takes input bit 7-code[i]
  function automatic logic [7:0] bit_perm(input logic [7:0] b, input logic [23:0] codes);
    logic [7:0] r;
    logic [2:0] code;
    r = '0;
    for (int i = 0; i < 8; i++) begin
      code = codes[3*i +: 3];
      r[7-i] = b[3'd7 - code];
    end
    return r;
  endfunction

endpackage

/* hw/rtl/spn16_ctr_keystream_cipher_core.sv */
// Channel   Direction  Handshake            Payload
// in_       input      in_valid/in_ready    command, sbox_index, sbox_value, data_block,
//                                           first_block, last_block
// out_      output     out_valid/out_ready  result_block, result_last
// cfg       input      psel/penable/pready  paddr, pwdata, prdata (APB, regs at 0x0/0x4/0x8)
//
// An S-box load is written as it is accepted; a data block with first_block set
// first makes two dependent S-box reads for key expansion. The pace is set by the S-box
// RAM: two reads per round, 3 rounds, one round per cycle but for a held final round.
// Reset is synchronous; S-box entries read as zero until written (per-entry valid bits).
// A result waits in the output register while the next item is accepted; the final
// round holds only while that register is still occupied.
module spn16_ctr_keystream_cipher_core
  import spn16_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic        in_command,
  input  logic [7:0]  in_sbox_index,
  input  logic [7:0]  in_sbox_value,
  input  logic [15:0] in_data_block,
  input  logic        in_first_block,
  input  logic        in_last_block,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [15:0] out_result_block,
  output logic        out_result_last,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [3:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  cfg_t       cfg;
  ram_req_t   ram_req;
  logic [7:0] rdata0;
  logic [7:0] rdata1;

  // Configuration registers
  spn16_apb_regs u_regs (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  // S-box store
  spn16_sbox_ram u_sbox (
    .clk    (clk),
    .rst_n  (rst_n),
    .req    (ram_req),
    .rdata0 (rdata0),
    .rdata1 (rdata1)
  );

  // Round sequencer and output register
  spn16_round_ctrl u_ctrl (
    .clk              (clk),
    .rst_n            (rst_n),
    .cfg              (cfg),
    .in_valid         (in_valid),
    .in_ready         (in_ready),
    .in_command       (in_command),
    .in_sbox_index    (in_sbox_index),
    .in_sbox_value    (in_sbox_value),
    .in_data_block    (in_data_block),
    .in_first_block   (in_first_block),
    .in_last_block    (in_last_block),
    .ram_req          (ram_req),
    .rdata0           (rdata0),
    .rdata1           (rdata1),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_result_block (out_result_block),
    .out_result_last  (out_result_last)
  );

endmodule

/* hw/rtl/spn16_apb_regs.sv */
module spn16_apb_regs
  import spn16_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [3:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready,
  output cfg_t        cfg
);

  cfg_t       cfg_r;
  logic       wr_hit;
  logic [1:0] reg_idx;

  assign pready  = 1'b1;
  assign reg_idx = paddr[3:2];
  assign wr_hit  = psel && penable && pwrite && pready;
  assign cfg     = cfg_r;

  // Update a register on the access phase of a write transfer
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.cipher_key   <= '0;
      cfg_r.pbox_codes   <= PBOX_RESET;
      cfg_r.counter_high <= '0;
    end else if (wr_hit) begin
      unique case (reg_idx)
        REG_CIPHER_KEY:   cfg_r.cipher_key   <= pwdata[15:0];
        REG_PBOX_CODES:   cfg_r.pbox_codes   <= pwdata[23:0];
        REG_COUNTER_HIGH: cfg_r.counter_high <= pwdata[7:0];
        default: ;
      endcase
    end
  end

  // Read back
  always_comb begin
    unique case (reg_idx)
      REG_CIPHER_KEY:   prdata = {16'h0000, cfg_r.cipher_key};
      REG_PBOX_CODES:   prdata = {8'h00, cfg_r.pbox_codes};
      REG_COUNTER_HIGH: prdata = {24'h000000, cfg_r.counter_high};
      default:          prdata = '0;
    endcase
  end

endmodule

/* hw/rtl/spn16_sbox_ram.sv */
module spn16_sbox_ram
  import spn16_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  ram_req_t   req,
  output logic [7:0] rdata0,
  output logic [7:0] rdata1
);

  logic [7:0]   mem [256];
  logic [255:0] vld_r;
  logic [7:0]   raw0_r;
  logic [7:0]   raw1_r;
  logic         hit0_r;
  logic         hit1_r;

  // One write port, two registered read ports
  always_ff @(posedge clk) begin
    if (req.wr_en) begin
      mem[req.wr_addr] <= req.wr_data;
    end
    if (req.rd_en) begin
      raw0_r <= mem[req.rd_addr0];
      raw1_r <= mem[req.rd_addr1];
    end
  end

  // Track written entries; an unwritten entry reads as zero
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r  <= '0;
      hit0_r <= 1'b0;
      hit1_r <= 1'b0;
    end else begin
      if (req.wr_en) begin
        vld_r[req.wr_addr] <= 1'b1;
      end
      if (req.rd_en) begin
        hit0_r <= vld_r[req.rd_addr0];
        hit1_r <= vld_r[req.rd_addr1];
      end
    end
  end

  assign rdata0 = hit0_r ? raw0_r : 8'h00;
  assign rdata1 = hit1_r ? raw1_r : 8'h00;

endmodule

/* hw/rtl/spn16_round_ctrl.sv */
`include "spn16_ctr_keystream_cipher_core_defines.svh"

module spn16_round_ctrl
  import spn16_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  cfg_t        cfg,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic        in_command,
  input  logic [7:0]  in_sbox_index,
  input  logic [7:0]  in_sbox_value,
  input  logic [15:0] in_data_block,
  input  logic        in_first_block,
  input  logic        in_last_block,
  output ram_req_t    ram_req,
  input  logic [7:0]  rdata0,
  input  logic [7:0]  rdata1,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [15:0] out_result_block,
  output logic        out_result_last
);

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_KEY1 = 2'd1;
  localparam logic [1:0] ST_KEY2 = 2'd2;
  localparam logic [1:0] ST_RND  = 2'd3;

  localparam logic [1:0] LAST_RND = 2'(ROUNDS - 1);

  logic [1:0]  state_r, state_nxt;
  logic [1:0]  rnd_r, rnd_nxt;
  logic [7:0]  ctr_low_r, ctr_low_nxt;
  logic [15:0] data_r;
  logic        last_r;
  logic [15:0] rk_r [3];
  logic [15:0] rk0_nxt, rk1_nxt, rk2_nxt;
  logic        out_valid_r, out_valid_nxt;
  logic [15:0] out_block_r, out_block_nxt;
  logic        out_last_r, out_last_nxt;

  logic        acc;
  logic        acc_data;
  logic [7:0]  ctr_use;
  logic [15:0] perm;
  logic [15:0] rk_next;
  logic        fin_ok;
  logic        fin;
  logic [7:0]  w2, w3, w4, w5;

  assign in_ready = (state_r == ST_IDLE);
  assign acc      = in_valid && in_ready;
  assign acc_data = acc && in_command;
  assign ctr_use  = in_first_block ? 8'h00 : ctr_low_r;
  assign fin_ok   = !out_valid_r || out_ready;
  assign fin      = (state_r == ST_RND) && (rnd_r == LAST_RND) && fin_ok;

  // Substitution output through the permutation, both bytes
  assign perm = {bit_perm(rdata0, cfg.pbox_codes), bit_perm(rdata1, cfg.pbox_codes)};

  // Key for the round that follows the one now returning
  assign rk_next = (rnd_r == 2'd0) ? rk_r[1] : rk_r[2];

  // Key schedule words from the returning S-box byte
  assign w2 = rk_r[0][15:8] ^ KEY_RCON1 ^ rdata0;
  assign w3 = w2 ^ rk_r[0][7:0];
  assign w4 = rk_r[1][15:8] ^ KEY_RCON2 ^ rdata0;
  assign w5 = w4 ^ rk_r[1][7:0];

  // Sequence memory reads and key/round updates
  always_comb begin
    state_nxt     = state_r;
    rnd_nxt       = rnd_r;
    ctr_low_nxt   = ctr_low_r;
    rk0_nxt       = rk_r[0];
    rk1_nxt       = rk_r[1];
    rk2_nxt       = rk_r[2];
    out_valid_nxt = out_valid_r && !out_ready;
    out_block_nxt = out_block_r;
    out_last_nxt  = out_last_r;

    ram_req.wr_en    = acc && !in_command;
    ram_req.wr_addr  = in_sbox_index;
    ram_req.wr_data  = in_sbox_value;
    ram_req.rd_en    = 1'b0;
    ram_req.rd_addr0 = 8'h00;
    ram_req.rd_addr1 = 8'h00;

    unique case (state_r)
      ST_IDLE: begin
        if (acc_data) begin
          ctr_low_nxt = ctr_use + 8'd1;
          ram_req.rd_en = 1'b1;
          if (in_first_block) begin
            // Start key expansion: fetch S[swap(w1)]
            rk0_nxt = cfg.cipher_key;
            ram_req.rd_addr0 = nib_swap(cfg.cipher_key[7:0]);
            state_nxt = ST_KEY1;
          end else begin
            // First round straight from the counter
            {ram_req.rd_addr0, ram_req.rd_addr1} = {cfg.counter_high, ctr_use} ^ rk_r[0];
            rnd_nxt = 2'd0;
            state_nxt = ST_RND;
          end
        end
      end
      ST_KEY1: begin
        rk1_nxt = {w2, w3};
        ram_req.rd_en = 1'b1;
        ram_req.rd_addr0 = nib_swap(w3);
        state_nxt = ST_KEY2;
      end
      ST_KEY2: begin
        // Finish the schedule and launch round zero on {high, 0}
        rk2_nxt = {w4, w5};
        ram_req.rd_en = 1'b1;
        {ram_req.rd_addr0, ram_req.rd_addr1} = {cfg.counter_high, 8'h00} ^ rk_r[0];
        rnd_nxt = 2'd0;
        state_nxt = ST_RND;
      end
      ST_RND: begin
        if (rnd_r != LAST_RND) begin
          ram_req.rd_en = 1'b1;
          {ram_req.rd_addr0, ram_req.rd_addr1} = perm ^ rk_next;
          rnd_nxt = rnd_r + 2'd1;
        end else if (fin_ok) begin
          // Drop the keystream onto the data into the output register
          out_valid_nxt = 1'b1;
          out_block_nxt = data_r ^ perm;
          out_last_nxt  = last_r;
          state_nxt     = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  // Control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      rnd_r       <= 2'd0;
      ctr_low_r   <= 8'h00;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      rnd_r       <= rnd_nxt;
      ctr_low_r   <= ctr_low_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Payload and round keys
  always_ff @(posedge clk) begin
    if (acc_data) begin
      data_r <= in_data_block;
      last_r <= in_last_block;
    end
    rk_r[0]     <= rk0_nxt;
    rk_r[1]     <= rk1_nxt;
    rk_r[2]     <= rk2_nxt;
    out_block_r <= out_block_nxt;
    out_last_r  <= out_last_nxt;
  end

  assign out_valid        = out_valid_r;
  assign out_result_block = out_block_r;
  assign out_result_last  = out_last_r;

  `SPN16_ASSERT_IMPL(a_wr_only_idle, ram_req.wr_en, (state_r == ST_IDLE) && !ram_req.rd_en, "S-box write overlaps a read")
  `SPN16_ASSERT_NEXT(a_first_expands, acc_data && in_first_block, state_r == ST_KEY1, "first block skipped key expansion")
  `SPN16_ASSERT_NEXT(a_ctr_advance, acc_data, ctr_low_r == $past(ctr_use) + 8'd1, "counter low byte did not advance")
  `SPN16_ASSERT_NEXT(a_fin_presents, fin, out_valid_r && (state_r == ST_IDLE), "finished block not presented")

endmodule
